// ===== rtl/pta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pta_pkg;

    localparam int LOG_FRAC   = 24;
    localparam int LAYERS     = 7;
    localparam int QDEPTH     = 4;
    localparam int ALT_W      = 25;
    localparam int H_W        = 40;

    localparam logic signed [H_W-1:0] ALT_MIN_CM = -40'sd100000;
    localparam logic signed [H_W-1:0] ALT_MAX_CM = 40'sd11000000;
    localparam logic [2:0]            TOP_LAYER  = 3'd6;

    // Reference pressures of each layer in Q.8 pascals.
    localparam longint unsigned REF_P_Q8 [0:LAYERS-1] =
        '{64'd25939200, 64'd5793818, 64'd1401572, 64'd222213,
          64'd28393, 64'd17137, 64'd1014};
    localparam longint BASE_CM [0:LAYERS-1] =
        '{64'sd0, 64'sd1100000, 64'sd2000000, 64'sd3200000,
          64'sd4700000, 64'sd5100000, 64'sd7100000};
    localparam bit ISO_LAYER [0:LAYERS-1] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    localparam longint ISO_K [0:LAYERS-1] =
        '{64'sd0, 64'sd439575, 64'sd0, 64'sd0, 64'sd549139, 64'sd0, 64'sd0};
    localparam longint POW_C [0:LAYERS-1] =
        '{64'sd3192141, 64'sd0, -64'sd491099, -64'sd1375076,
          64'sd0, 64'sd1375076, 64'sd982197};
    localparam longint POW_D [0:LAYERS-1] =
        '{-64'sd4433077, 64'sd0, 64'sd21665000, 64'sd8166071,
          64'sd0, -64'sd9666071, -64'sd10732500};

    typedef struct packed {
        logic [2:0] layer;
        logic       bad;
    } meta_t;

    typedef struct packed {
        logic [30:0] m;
        logic [4:0]  top;
        meta_t       meta;
    } item_t;

    typedef struct packed {
        meta_t                  meta;
        logic signed [H_W-1:0]  h_iso;
    } side_t;

    // log2 in Q.24 by repeated squaring; evaluated only at elaboration.
    function automatic longint log2_q24(longint unsigned v);
        int unsigned     top;
        longint unsigned m;
        longint          frac;
        top  = 0;
        frac = 0;
        while (top < 63 && (v >> (top + 1)) != 0)
            top++;
        m = (top <= 30) ? (v << (30 - top)) : (v >> (top - 30));
        for (int i = 0; i < LOG_FRAC; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac = frac | 64'sd1;
            end
        end
        return longint'(top) * (64'sd1 << LOG_FRAC) + frac;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned x;
        r = 0;
        x = v;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q1.30, each entry the floor square root of the previous one.
    function automatic longint unsigned exp_tab(int k);
        longint unsigned t;
        t = 64'd2 << 30;
        for (int j = 1; j <= k; j++)
            t = isqrt64(t << 30);
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pressure_to_altitude_layered_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts absolute pressure to geopotential altitude in the standard atmosphere.
// Input request: pressure_q8 (unsigned pascals with PRESSURE_FRAC_BITS fraction bits),
// taken at an edge where pressure_valid is high and pressure_stall is low.
// Output request: altitude_cm (signed centimeters, saturated), layer and bad_pressure,
// taken at an edge where result_valid is high and result_stall is low.
// The front classifies each pressure into a layer and normalizes it, then places it
// in a four-entry queue. The back is a fully pipelined log2 / exp2 datapath of
// 24 squaring stages, 24 table-multiply stages and a few multiply and round stages.
// Throughput is one request per cycle while result_stall is not holding a finished result.
// When result_stall holds a finished result, the whole back pipeline freezes; the
// queue keeps accepting until it is full, and then pressure_stall rises.
// A zero pressure yields layer 6, the maximum altitude and bad_pressure high.
// Reset clears all valid bits and the queue; no request is in flight afterwards.

module pressure_to_altitude_layered_core #(
    parameter int PRESSURE_FRAC_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pressure_valid,
    output logic                    pressure_stall,
    input  wire logic [24:0]        pressure_q8,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [24:0]      altitude_cm,
    output logic [2:0]              layer,
    output logic                    bad_pressure
);

    localparam logic [28:0] LOG2_PB [0:pta_pkg::LAYERS-1] = '{
        29'(pta_pkg::log2_q24(pta_pkg::REF_P_Q8[0])),
        29'(pta_pkg::log2_q24(pta_pkg::REF_P_Q8[1])),
        29'(pta_pkg::log2_q24(pta_pkg::REF_P_Q8[2])),
        29'(pta_pkg::log2_q24(pta_pkg::REF_P_Q8[3])),
        29'(pta_pkg::log2_q24(pta_pkg::REF_P_Q8[4])),
        29'(pta_pkg::log2_q24(pta_pkg::REF_P_Q8[5])),
        29'(pta_pkg::log2_q24(pta_pkg::REF_P_Q8[6]))};
    localparam longint OFF_Q24 = longint'(PRESSURE_FRAC_BITS - 8) * (64'sd1 << 24);
    localparam logic signed [36:0] ONE_Q30 = 37'sd1073741824;

    pta_pkg::item_t     fr_item;
    pta_pkg::item_t     q_head;
    logic               q_empty;
    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               en;

    logic               lg_valid;
    logic [28:0]        lg_log;
    pta_pkg::meta_t     lg_meta;

    logic               y_valid_reg;
    logic signed [31:0] y_reg;
    pta_pkg::meta_t     y_meta_reg;

    logic               m1_valid_reg;
    logic               m1_neg_reg;
    logic [31:0]        m1_magy_reg;
    logic [22:0]        m1_magc_reg;
    pta_pkg::meta_t     m1_meta_reg;
    logic signed [23:0] coef;

    logic               m2_valid_reg;
    logic               m2_neg_reg;
    logic [54:0]        m2_prod_reg;
    pta_pkg::meta_t     m2_meta_reg;

    logic [54:0]        m3_rnd;
    logic signed [32:0] m3_val;
    pta_pkg::side_t     ex_in_side;

    logic               ex_valid;
    logic signed [7:0]  ex_n;
    logic [30:0]        ex_r;
    pta_pkg::side_t     ex_side;

    logic signed [7:0]  nc;
    logic [35:0]        x_val;
    logic               x_valid_reg;
    logic signed [36:0] x_xm1_reg;
    pta_pkg::side_t     x_side_reg;

    logic signed [25:0] dcoef;
    logic               d1_valid_reg;
    logic               d1_neg_reg;
    logic [24:0]        d1_magd_reg;
    logic [35:0]        d1_magx_reg;
    pta_pkg::side_t     d1_side_reg;

    logic               d2_valid_reg;
    logic               d2_neg_reg;
    logic [42:0]        d2_lo_reg;
    logic [42:0]        d2_hi_reg;
    pta_pkg::side_t     d2_side_reg;

    logic [61:0]        d3_rnd;
    logic signed [32:0] d3_val;
    logic               d3_valid_reg;
    logic signed [39:0] d3_hpow_reg;
    pta_pkg::side_t     d3_side_reg;

    logic signed [39:0] h_sel;
    logic signed [39:0] h_clamp;

    // The back advances unless a finished result is held by the receiver.
    assign en             = !result_valid || !result_stall;
    assign q_push         = pressure_valid && !pressure_stall;
    assign q_pop          = en && !q_empty;
    assign pressure_stall = q_full;

    pta_front #(
        .PRESSURE_FRAC_BITS(PRESSURE_FRAC_BITS)
    ) u_front (
        .pressure_q8(pressure_q8),
        .item(fr_item)
    );

    pta_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_item(fr_item),
        .pop(q_pop),
        .head_item(q_head),
        .empty(q_empty),
        .full(q_full)
    );

    pta_log2 u_log2 (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(q_pop),
        .in_item(q_head),
        .out_valid(lg_valid),
        .out_log(lg_log),
        .out_meta(lg_meta)
    );

    always_comb
    begin
        coef = pta_pkg::ISO_LAYER[y_meta_reg.layer] ? 24'(pta_pkg::ISO_K[y_meta_reg.layer])
                                                     : 24'(pta_pkg::POW_C[y_meta_reg.layer]);
    end

    always_comb
    begin
        m3_rnd = m2_prod_reg + (55'd1 << 23);
        m3_val = m2_neg_reg ? -$signed({2'b0, m3_rnd[54:24]}) : $signed({2'b0, m3_rnd[54:24]});
        ex_in_side.meta  = m2_meta_reg;
        ex_in_side.h_iso = 40'(pta_pkg::BASE_CM[m2_meta_reg.layer]) - 40'(m3_val);
    end

    pta_exp2 u_exp2 (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(m2_valid_reg),
        .z(m3_val[31:0]),
        .in_side(ex_in_side),
        .out_valid(ex_valid),
        .out_n(ex_n),
        .out_r(ex_r),
        .out_side(ex_side)
    );

    always_comb
    begin
        nc = ex_n;
        if (ex_n > 8'sd4)
            nc = 8'sd4;
        else if (ex_n < -8'sd31)
            nc = -8'sd31;
        if (!nc[7])
            x_val = 36'(ex_r) << nc[2:0];
        else
            x_val = 36'(ex_r) >> 5'(-nc);
    end

    assign dcoef = 26'(pta_pkg::POW_D[x_side_reg.meta.layer]);

    always_comb
    begin
        d3_rnd = 62'(d2_lo_reg) + (62'(d2_hi_reg) << 18) + (62'd1 << 29);
        d3_val = d2_neg_reg ? -$signed({1'b0, d3_rnd[61:30]}) : $signed({1'b0, d3_rnd[61:30]});
    end

    always_comb
    begin
        h_sel = pta_pkg::ISO_LAYER[d3_side_reg.meta.layer] ? d3_side_reg.h_iso : d3_hpow_reg;
        h_clamp = h_sel;
        if (h_sel < pta_pkg::ALT_MIN_CM)
            h_clamp = pta_pkg::ALT_MIN_CM;
        if (h_sel > pta_pkg::ALT_MAX_CM)
            h_clamp = pta_pkg::ALT_MAX_CM;
        if (d3_side_reg.meta.bad)
            h_clamp = pta_pkg::ALT_MAX_CM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_valid_reg  <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            x_valid_reg  <= 1'b0;
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else if (en)
        begin
            y_valid_reg  <= lg_valid;
            m1_valid_reg <= y_valid_reg;
            m2_valid_reg <= m1_valid_reg;
            x_valid_reg  <= ex_valid;
            d1_valid_reg <= x_valid_reg;
            d2_valid_reg <= d1_valid_reg;
            d3_valid_reg <= d2_valid_reg;
            result_valid <= d3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= $signed({3'b0, lg_log}) - $signed({3'b0, LOG2_PB[lg_meta.layer]})
                     - 32'(OFF_Q24);
            y_meta_reg <= lg_meta;

            m1_neg_reg  <= y_reg[31] ^ coef[23];
            m1_magy_reg <= y_reg[31] ? 32'(-y_reg) : 32'(y_reg);
            m1_magc_reg <= coef[23] ? 23'(-coef) : coef[22:0];
            m1_meta_reg <= y_meta_reg;

            m2_neg_reg  <= m1_neg_reg;
            m2_prod_reg <= 55'(m1_magc_reg) * 55'(m1_magy_reg);
            m2_meta_reg <= m1_meta_reg;

            x_xm1_reg  <= $signed({1'b0, x_val}) - ONE_Q30;
            x_side_reg <= ex_side;

            d1_neg_reg  <= x_xm1_reg[36] ^ dcoef[25];
            d1_magd_reg <= dcoef[25] ? 25'(-dcoef) : dcoef[24:0];
            d1_magx_reg <= x_xm1_reg[36] ? 36'(-x_xm1_reg) : x_xm1_reg[35:0];
            d1_side_reg <= x_side_reg;

            d2_neg_reg  <= d1_neg_reg;
            d2_lo_reg   <= 43'(d1_magd_reg) * 43'(d1_magx_reg[17:0]);
            d2_hi_reg   <= 43'(d1_magd_reg) * 43'(d1_magx_reg[35:18]);
            d2_side_reg <= d1_side_reg;

            d3_hpow_reg <= 40'(pta_pkg::BASE_CM[d2_side_reg.meta.layer]) + 40'(d3_val);
            d3_side_reg <= d2_side_reg;

            altitude_cm  <= h_clamp[24:0];
            layer        <= d3_side_reg.meta.bad ? pta_pkg::TOP_LAYER : d3_side_reg.meta.layer;
            bad_pressure <= d3_side_reg.meta.bad;
        end
    end

    a_bad_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bad_pressure |-> altitude_cm == 25'sd11000000 && layer == 3'd6)
        else $error("bad pressure result not saturated");

    a_alt_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> altitude_cm >= -25'sd100000 && altitude_cm <= 25'sd11000000)
        else $error("altitude outside output range");

    a_stall_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pressure_stall) |-> $past(pressure_valid))
        else $error("queue filled without a request");

endmodule

`default_nettype wire

// ===== rtl/pta_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pta_front #(
    parameter int PRESSURE_FRAC_BITS = 8
) (
    input  wire logic [24:0]    pressure_q8,
    output pta_pkg::item_t      item
);

    logic [2:0]  layer_cnt;
    logic [4:0]  top;
    logic [47:0] p_scaled;

    assign p_scaled = 48'(pressure_q8) << 8;

    // A pressure at or below a layer's reference pressure belongs to that layer or above.
    always_comb
    begin
        layer_cnt = 3'd0;
        for (int b = 1; b < pta_pkg::LAYERS; b++)
        begin
            if (p_scaled <= (48'(pta_pkg::REF_P_Q8[b]) << PRESSURE_FRAC_BITS))
                layer_cnt = layer_cnt + 3'd1;
        end
    end

    always_comb
    begin
        top = 5'd0;
        for (int i = 0; i < 25; i++)
        begin
            if (pressure_q8[i])
                top = 5'(i);
        end
    end

    always_comb
    begin
        item.m          = 31'({6'b0, pressure_q8} << (5'd30 - top));
        item.top        = top;
        item.meta.layer = layer_cnt;
        item.meta.bad   = (pressure_q8 == 25'd0);
    end

endmodule

`default_nettype wire

// ===== rtl/pta_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pta_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  pta_pkg::item_t      push_item,
    input  wire logic           pop,
    output pta_pkg::item_t      head_item,
    output logic                empty,
    output logic                full
);

    localparam int PW = $clog2(pta_pkg::QDEPTH);
    localparam int CW = $clog2(pta_pkg::QDEPTH + 1);

    pta_pkg::item_t mem [pta_pkg::QDEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(pta_pkg::QDEPTH));
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== rtl/pta_log2.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pta_log2 (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  pta_pkg::item_t      in_item,
    output logic                out_valid,
    output logic [28:0]         out_log,
    output pta_pkg::meta_t      out_meta
);

    localparam int N = pta_pkg::LOG_FRAC;

    logic [N:0]         v_reg;
    logic [30:0]        m_reg    [N+1];
    logic [N-1:0]       f_reg    [N+1];
    logic [4:0]         top_reg  [N+1];
    pta_pkg::meta_t     meta_reg [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= in_item.m;
            f_reg[0]    <= '0;
            top_reg[0]  <= in_item.top;
            meta_reg[0] <= in_item.meta;
        end
    end

    // Each stage squares the mantissa and takes one fraction bit when it reaches 2.0.
    for (genvar i = 1; i <= N; i++)
    begin : g_sq
        logic [61:0] sq;
        assign sq = 62'(m_reg[i-1]) * 62'(m_reg[i-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i]    <= sq[61] ? sq[61:31] : sq[60:30];
                f_reg[i]    <= {f_reg[i-1][N-2:0], sq[61]};
                top_reg[i]  <= top_reg[i-1];
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_log   = {top_reg[N], f_reg[N]};
    assign out_meta  = meta_reg[N];

endmodule

`default_nettype wire

// ===== rtl/pta_exp2.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pta_exp2 (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic signed [31:0] z,
    input  pta_pkg::side_t      in_side,
    output logic                out_valid,
    output logic signed [7:0]   out_n,
    output logic [30:0]         out_r,
    output pta_pkg::side_t      out_side
);

    localparam int N = pta_pkg::LOG_FRAC;

    logic [N:0]             v_reg;
    logic [30:0]            r_reg    [N+1];
    logic [N-1:0]           f_reg    [N+1];
    logic signed [7:0]      n_reg    [N+1];
    pta_pkg::side_t         side_reg [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-1:0], in_valid};
    end

    // The integer part is the floor of z; the fraction is always non-negative.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= 31'h4000_0000;
            f_reg[0]    <= z[N-1:0];
            n_reg[0]    <= z[31:24];
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_mul
        localparam logic [30:0] TK = 31'(pta_pkg::exp_tab(k));
        logic [61:0] prod;
        assign prod = 62'(r_reg[k-1]) * 62'(TK);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]    <= f_reg[k-1][N-k] ? prod[60:30] : r_reg[k-1];
                f_reg[k]    <= f_reg[k-1];
                n_reg[k]    <= n_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_n     = n_reg[N];
    assign out_r     = r_reg[N];
    assign out_side  = side_reg[N];

endmodule

`default_nettype wire
